### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LRU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LRU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LRU_ASSERT(name, clk, rst_n, prop, msg)

`define LRU_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### rtl/lru_pkg.sv
package lru_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam int CFG_W   = 4;
  localparam int FIDX_W  = 3;
  localparam int FAULT_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [FIDX_W-1:0] frame_index;
  } res_flags_t;

endpackage

### rtl/lru_req_if.sv
interface lru_req_if #(
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;
  logic                 last_in_run;

  modport source (output valid, output page_number, output last_in_run, input ready);
  modport sink   (input valid, input page_number, input last_in_run, output ready);
endinterface

### rtl/lru_res_if.sv
interface lru_res_if #(
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [lru_pkg::FIDX_W-1:0]        frame_index;
  logic                              evicted_valid;
  logic [PAGE_BITS-1:0]              evicted_page;
  logic [lru_pkg::FAULT_W-1:0]       fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

### rtl/lru_ram.sv
module lru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/lru_ctrl.sv
`include "assert_macros.svh"

module lru_ctrl #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lru_pkg::CFG_W-1:0]     frames_cfg,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [PAGE_BITS-1:0]          req_page,
  input  logic                          req_last,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lru_pkg::res_flags_t           res_flags,
  output logic [PAGE_BITS-1:0]          res_evicted_page,
  output logic [lru_pkg::FAULT_W-1:0]   res_fault_count
);
  import lru_pkg::*;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int RANK_W = IDX_W;
  localparam int ENT_W  = PAGE_BITS + RANK_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);
  localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(FRAMES);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STATE_W-1:0] ST_SCAN = 3'd1;
  localparam logic [STATE_W-1:0] ST_DEC  = 3'd2;
  localparam logic [STATE_W-1:0] ST_UPD  = 3'd3;
  localparam logic [STATE_W-1:0] ST_FIN  = 3'd4;

  logic [STATE_W-1:0]   state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 last_r, last_nxt;
  logic [CNT_W-1:0]     act_r, act_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     hf_r, hf_nxt;
  logic [RANK_W-1:0]    hrank_r, hrank_nxt;
  logic                 emp_r, emp_nxt;
  logic [IDX_W-1:0]     ef_r, ef_nxt;
  logic [RANK_W-1:0]    best_r, best_nxt;
  logic [IDX_W-1:0]     vf_r, vf_nxt;
  logic [PAGE_BITS-1:0] vpage_r, vpage_nxt;
  logic [IDX_W-1:0]     f_r, f_nxt;
  logic [RANK_W-1:0]    orank_r, orank_nxt;
  logic                 age_all_r, age_all_nxt;
  logic                 evv_r, evv_nxt;
  logic [PAGE_BITS-1:0] epage_r, epage_nxt;
  logic [FAULT_W-1:0]   faults_r, faults_nxt;
  logic [FRAMES-1:0]    valid_r, valid_nxt;

  logic                 rd_en, wr_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data, wr_data;
  logic [PAGE_BITS-1:0] ent_page;
  logic [RANK_W-1:0]    ent_rank;
  logic                 cur_act, cur_v;
  logic [CNT_W-1:0]     act_clamp;
  logic [31:0]          f_ext;

  lru_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FRAMES),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pidx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent_page = rd_data[ENT_W-1:RANK_W];
  assign ent_rank = rd_data[RANK_W-1:0];
  assign cur_act  = {1'b0, pidx_r} < act_r;
  assign cur_v    = valid_r[pidx_r];
  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign rd_en    = ((state_r == ST_SCAN) || (state_r == ST_UPD)) && (cnt_r < FRAMES_C);

  always_comb begin
    if (frames_cfg == '0) begin
      act_clamp = CNT_W'(1);
    end else if (int'(frames_cfg) > FRAMES) begin
      act_clamp = FRAMES_C;
    end else begin
      act_clamp = CNT_W'(frames_cfg);
    end
  end

  assign req_ready        = (state_r == ST_IDLE);
  assign res_valid        = (state_r == ST_FIN);
  assign f_ext            = 32'(f_r);
  assign res_flags        = '{hit: hit_r, evicted_valid: evv_r,
                              frame_index: f_ext[FIDX_W-1:0]};
  assign res_evicted_page = epage_r;
  assign res_fault_count  = faults_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = rd_en ? cnt_r + CNT_W'(1) : cnt_r;
    pend_nxt    = rd_en;
    pidx_nxt    = rd_addr;
    page_nxt    = page_r;
    last_nxt    = last_r;
    act_nxt     = act_r;
    hit_nxt     = hit_r;
    hf_nxt      = hf_r;
    hrank_nxt   = hrank_r;
    emp_nxt     = emp_r;
    ef_nxt      = ef_r;
    best_nxt    = best_r;
    vf_nxt      = vf_r;
    vpage_nxt   = vpage_r;
    f_nxt       = f_r;
    orank_nxt   = orank_r;
    age_all_nxt = age_all_r;
    evv_nxt     = evv_r;
    epage_nxt   = epage_r;
    faults_nxt  = faults_r;
    valid_nxt   = valid_r;
    wr_en       = 1'b0;
    wr_data     = rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          page_nxt  = req_page;
          last_nxt  = req_last;
          act_nxt   = act_clamp;
          hit_nxt   = 1'b0;
          emp_nxt   = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          // frame 0 is always active: seed the oldest-frame search with it
          if (pidx_r == '0 || (cur_act && ent_rank > best_r)) begin
            best_nxt  = ent_rank;
            vf_nxt    = pidx_r;
            vpage_nxt = ent_page;
          end
          if (cur_act && cur_v && ent_page == page_r && !hit_r) begin
            hit_nxt   = 1'b1;
            hf_nxt    = pidx_r;
            hrank_nxt = ent_rank;
          end
          if (cur_act && !cur_v && !emp_r) begin
            emp_nxt = 1'b1;
            ef_nxt  = pidx_r;
          end
          if (pidx_r == LAST_IDX) begin
            cnt_nxt   = '0;
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        age_all_nxt = 1'b0;
        evv_nxt     = 1'b0;
        epage_nxt   = '0;
        if (hit_r) begin
          f_nxt     = hf_r;
          orank_nxt = hrank_r;
        end else begin
          if (faults_r != '1) begin
            faults_nxt = faults_r + FAULT_W'(1);
          end
          if (emp_r) begin
            f_nxt       = ef_r;
            age_all_nxt = 1'b1;
          end else begin
            f_nxt     = vf_r;
            orank_nxt = best_r;
            evv_nxt   = 1'b1;
            epage_nxt = vpage_r;
          end
        end
        cnt_nxt   = '0;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (pend_r) begin
          if (pidx_r == f_r) begin
            wr_en             = 1'b1;
            wr_data           = {page_r, RANK_W'(0)};
            valid_nxt[pidx_r] = 1'b1;
          end else if (cur_v && (age_all_r || ent_rank < orank_r)) begin
            wr_en   = 1'b1;
            wr_data = {ent_page, ent_rank + RANK_W'(1)};
          end
          if (pidx_r == LAST_IDX) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            valid_nxt  = '0;
            faults_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      valid_r  <= '0;
      faults_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      valid_r  <= valid_nxt;
      faults_r <= faults_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r    <= pidx_nxt;
    page_r    <= page_nxt;
    last_r    <= last_nxt;
    act_r     <= act_nxt;
    hit_r     <= hit_nxt;
    hf_r      <= hf_nxt;
    hrank_r   <= hrank_nxt;
    emp_r     <= emp_nxt;
    ef_r      <= ef_nxt;
    best_r    <= best_nxt;
    vf_r      <= vf_nxt;
    vpage_r   <= vpage_nxt;
    f_r       <= f_nxt;
    orank_r   <= orank_nxt;
    age_all_r <= age_all_nxt;
    evv_r     <= evv_nxt;
    epage_r   <= epage_nxt;
  end

  // write-back of one entry never collides with the read of the next
  `LRU_ASSERT(a_no_rw_clash, clk, rst_n, wr_en && rd_en |-> pidx_r != rd_addr, "ram read/write same entry")
  `LRU_ASSERT(a_hit_no_evict, clk, rst_n, state_r == ST_FIN |-> !(hit_r && evv_r), "eviction reported on a hit")
  `LRU_ASSERT(a_fill_one, clk, rst_n, state_r == ST_FIN |=> $countones(valid_r) <= $countones($past(valid_r)), "frames filled after result")
  `LRU_ASSERT(a_upd_one_fill, clk, rst_n, state_r == ST_UPD |=> $countones(valid_r) <= $countones($past(valid_r)) + 1, "more than one frame filled per request")

endmodule

### rtl/lru_page_replacement.sv
// LRU page replacement over a fully associative set of FRAMES page frames. Each request on
// in_req returns one result on out_res: hit or fault, the frame now holding the page, the
// evicted page if any, and the saturating fault count of the current run. cfg_wr_data sets
// how many frames are active (0 acts as 1, above FRAMES acts as FRAMES; reset value 3); write
// it only while no request is in flight. A request with last_in_run set empties the table and
// clears the fault count after its result. Pages and recency ranks live in one single-port-read
// frame memory; each request takes two sweeps through it, one entry per cycle: a scan for the
// match, the first empty frame and the oldest frame, then a read-modify-write pass that updates
// the ranks. A new request is taken only after the previous result has been handed on; a
// stalled output holds one result and lets the next request run up to its result.
module lru_page_replacement #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [lru_pkg::CFG_W-1:0] cfg_wr_data,
  lru_req_if.sink                   in_req,
  lru_res_if.source                 out_res
);
  import lru_pkg::*;

  logic [CFG_W-1:0]     cfg_r;
  logic                 out_valid_r;
  res_flags_t           flags_r;
  logic [PAGE_BITS-1:0] epage_r;
  logic [FAULT_W-1:0]   fault_r;

  logic                 res_valid, res_ready;
  res_flags_t           res_flags;
  logic [PAGE_BITS-1:0] res_epage;
  logic [FAULT_W-1:0]   res_fault;

  lru_ctrl #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .frames_cfg       (cfg_r),
    .req_valid        (in_req.valid),
    .req_ready        (in_req.ready),
    .req_page         (in_req.page_number),
    .req_last         (in_req.last_in_run),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res_flags        (res_flags),
    .res_evicted_page (res_epage),
    .res_fault_count  (res_fault)
  );

  assign res_ready = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      flags_r <= res_flags;
      epage_r <= res_epage;
      fault_r <= res_fault;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.hit           = flags_r.hit;
  assign out_res.frame_index   = flags_r.frame_index;
  assign out_res.evicted_valid = flags_r.evicted_valid;
  assign out_res.evicted_page  = epage_r;
  assign out_res.fault_count   = fault_r;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import lru_pkg::*;

  localparam int NF        = FRAMES_DEF;
  localparam int PB        = PAGE_BITS_DEF;
  localparam int DRAIN_CYC = 2 * NF + 5;
  localparam int MAX_CYC   = 400000;
  localparam int SEG_ITEMS = 112;
  localparam int POOL_N    = 10;

  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame_index;
    logic              evicted_valid;
    logic [PB-1:0]     evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } lru_result_t;

  typedef struct packed {
    logic             do_cfg;
    logic [CFG_W-1:0] cfg_val;
    logic [PB-1:0]    page;
    logic             last;
    logic             typed;
    lru_result_t      want;
  } stim_row_t;

  localparam int N_ROWS = 20;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{1'b0, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
    '{1'b0, 4'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2}},
    '{1'b0, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
    '{1'b0, 4'd0,  16'h1234, 1'b0, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 32'd3}},
    '{1'b0, 4'd0,  16'h5555, 1'b0, 1'b1, '{1'b0, 3'd1, 1'b1, 16'hFFFF, 32'd4}},
    '{1'b0, 4'd0,  16'hAAAA, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 32'd5}},
    // zero frames acts as one
    '{1'b1, 4'd0,  16'h0007, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
    '{1'b0, 4'd0,  16'h0008, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0007, 32'd2}},
    '{1'b0, 4'd0,  16'h0008, 1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
    // above built count acts as all frames
    '{1'b1, 4'd15, 16'h0100, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0101, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0102, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0103, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0104, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0105, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0106, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0107, 1'b0, 1'b0, '0},
    // shrink mid-run, then grow: page resident twice, lowest frame hits
    '{1'b1, 4'd2,  16'h0105, 1'b0, 1'b0, '0},
    '{1'b1, 4'd8,  16'h0105, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h8001, 1'b1, 1'b0, '0}
  };

  localparam int CFG_PLAN [12] = '{1, 8, 0, 15, 3, 5, 2, 7, 4, 6, 9, 12};

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  lru_req_if #(.PAGE_BITS(PB)) req_ch ();
  lru_res_if #(.PAGE_BITS(PB)) res_ch ();

  lru_page_replacement #(.FRAMES(NF), .PAGE_BITS(PB)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (req_ch.sink),
    .out_res     (res_ch.source)
  );

  // predictor state
  logic [PB-1:0]     pg_tag  [NF];
  logic              pg_live [NF];
  logic [2:0]        pg_age  [NF];
  logic [FAULT_W-1:0] run_faults;
  logic [CFG_W-1:0]  frames_cfg;

  lru_result_t pending_results [$];
  int mismatches;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  function automatic int active_frames();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > NF) return NF;
    return frames_cfg;
  endfunction

  function automatic void clear_frames();
    for (int i = 0; i < NF; i++) begin
      pg_tag[i]  = '0;
      pg_live[i] = 1'b0;
      pg_age[i]  = '0;
    end
    run_faults = '0;
  endfunction

  function automatic void promote_frame(int f, int old_age);
    for (int i = 0; i < NF; i++) begin
      if (i != f && pg_live[i] && pg_age[i] < old_age) pg_age[i] = pg_age[i] + 3'd1;
    end
    pg_age[f] = '0;
  endfunction

  function automatic lru_result_t predict_lookup(logic [PB-1:0] page, logic last);
    lru_result_t r;
    int n;
    int f;
    int best;
    bit found;
    bit hole;
    r = '0;
    n = active_frames();
    f = 0;
    found = 0;
    hole = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && pg_live[i] && pg_tag[i] == page) begin
        found = 1;
        f = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      promote_frame(f, pg_age[f]);
    end else begin
      if (run_faults != '1) run_faults = run_faults + FAULT_W'(1);
      for (int i = 0; i < n; i++) begin
        if (!hole && !pg_live[i]) begin
          hole = 1;
          f = i;
        end
      end
      if (hole) begin
        promote_frame(f, NF);
      end else begin
        best = 0;
        f = 0;
        for (int i = 0; i < n; i++) begin
          if (pg_age[i] > best) begin
            best = pg_age[i];
            f = i;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = pg_tag[f];
        promote_frame(f, pg_age[f]);
      end
      pg_tag[f]  = page;
      pg_live[f] = 1'b1;
    end
    r.frame_index = f[FIDX_W-1:0];
    r.fault_count = run_faults;
    if (last) clear_frames();
    return r;
  endfunction

  task automatic push_req(logic [PB-1:0] page, logic last, logic typed, lru_result_t want);
    lru_result_t pred;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.page_number <= page;
    req_ch.last_in_run <= last;
    do @(posedge clk); while (!req_ch.ready);
    pred = predict_lookup(page, last);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_frames(logic [CFG_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    frames_cfg = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    res_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : scoreboard
    lru_result_t seen;
    lru_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      seen = '{res_ch.hit, res_ch.frame_index, res_ch.evicted_valid,
               res_ch.evicted_page, res_ch.fault_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: hit=%0d frame=%0d ev=%0d ev_page=%h faults=%0d",
                   seen.hit, seen.frame_index, seen.evicted_valid, seen.evicted_page,
                   seen.fault_count);
      end else begin
        want = pending_results.pop_front();
        if (seen.hit !== want.hit || seen.frame_index !== want.frame_index ||
            seen.evicted_valid !== want.evicted_valid ||
            seen.evicted_page !== want.evicted_page ||
            seen.fault_count !== want.fault_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0d frame=%0d ev=%0d ev_page=%h faults=%0d",
                     want.hit, want.frame_index, want.evicted_valid, want.evicted_page,
                     want.fault_count,
                     " | got hit=%0d frame=%0d ev=%0d ev_page=%h faults=%0d",
                     seen.hit, seen.frame_index, seen.evicted_valid,
                     seen.evicted_page, seen.fault_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [PB-1:0] pool [POOL_N];
    logic [PB-1:0] page;
    logic          last;
    int            span;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.page_number = '0;
    req_ch.last_in_run = 1'b0;
    res_ch.ready       = 1'b0;
    mismatches         = 0;
    cycles             = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    frames_cfg         = CFG_RESET;
    clear_frames();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].do_cfg) write_frames(DIRECTED[r].cfg_val);
      push_req(DIRECTED[r].page, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int i = 0; i < POOL_N; i++) pool[i] = PB'($urandom_range(0, 65535));
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        write_frames(CFG_W'(CFG_PLAN[mode * 3 + seg]));
        for (int k = 0; k < SEG_ITEMS; k++) begin
          span = active_frames() + 2;
          if (span > POOL_N - 1) span = POOL_N - 1;
          if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, span)];
          else page = PB'($urandom_range(0, 65535));
          last = ($urandom_range(0, 29) == 0);
          push_req(page, last, 1'b0, '0);
          if (last)
            for (int i = 0; i < POOL_N; i++) pool[i] = PB'($urandom_range(0, 65535));
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
